@@ hw/rtl/qpe_pkg.sv @@
`default_nettype none
package qpe_pkg;

  localparam int unsigned QPE_FIFO_DEPTH = 4;
  localparam logic [7:0]  QPE_LIMIT_RESET = 8'd76;
  localparam logic [7:0]  QPE_COUNT_MAX   = 8'd255;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_TL = 8'h7E;

  typedef enum logic [1:0] {
    KIND_NEWLINE = 2'd0,
    KIND_LITERAL = 2'd1,
    KIND_ESCAPE  = 2'd2
  } kind_t;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic       brk;   // soft break goes out before the part
    kind_t      kind;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'd0, nib};
    end else begin
      res = 8'h37 + {4'd0, nib};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/quoted_printable_encoder.sv @@
// Channel   Dir  Width  Contents
// s_axis    in   8      tdata: in_byte
// m_axis    out  8+1    tdata: out_byte; tlast: out_last
// cfg       in   8      line_limit write (cfg_wen, cfg_wdata)
//
// Input bytes are taken one per cycle while the request queue has room.
// Output runs one byte per cycle while m_axis is ready: a literal byte gives 1 output byte,
// a newline 2, an escape 3, and a soft break adds 3; the output register is the limit.
// An accepted input byte passes through the queue slot and then the output register.
// rst is synchronous: clears line count, queue and output; limit returns to 76.
// Stalls on m_axis back up through the queue to s_axis tready.
`default_nettype none
module quoted_printable_encoder #(
  parameter int unsigned FIFO_DEPTH = qpe_pkg::QPE_FIFO_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wen,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast
);
  import qpe_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic head_valid;
  cmd_t head_cmd;

  qpe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  qpe_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  qpe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule
`default_nettype wire

@@ hw/rtl/qpe_front.sv @@
`default_nettype none
module qpe_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wen,
  input  wire logic [7:0]    cfg_wdata,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          q_full,
  output logic               q_push,
  output qpe_pkg::cmd_t      q_cmd
);
  import qpe_pkg::*;

  logic [7:0] line_limit;
  logic [7:0] line_length;
  logic [7:0] line_length_next;
  logic       is_nl;
  logic       literal;
  logic [8:0] part_len;
  logic       brk;
  logic [8:0] base;
  logic [8:0] sum;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    is_nl    = (in_byte == CH_LF);
    literal  = (in_byte >= CH_SP) && (in_byte <= CH_TL) && (in_byte != CH_EQ);
    part_len = literal ? 9'd1 : 9'd3;
    brk      = ({1'b0, line_length} + part_len) >= {1'b0, line_limit};
    base     = brk ? 9'd0 : {1'b0, line_length};
    sum      = base + part_len;
    if (is_nl) begin
      line_length_next = 8'd0;
    end else if (sum > {1'b0, QPE_COUNT_MAX}) begin
      line_length_next = QPE_COUNT_MAX;
    end else begin
      line_length_next = sum[7:0];
    end
    q_cmd.data = in_byte;
    q_cmd.brk  = brk && !is_nl;
    if (is_nl) begin
      q_cmd.kind = KIND_NEWLINE;
    end else if (literal) begin
      q_cmd.kind = KIND_LITERAL;
    end else begin
      q_cmd.kind = KIND_ESCAPE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit  <= QPE_LIMIT_RESET;
      line_length <= 8'd0;
    end else begin
      if (cfg_wen) begin
        line_limit <= cfg_wdata;
      end
      if (q_push) begin
        line_length <= line_length_next;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/qpe_fifo.sv @@
`default_nettype none
module qpe_fifo #(
  parameter int unsigned DEPTH = qpe_pkg::QPE_FIFO_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire qpe_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output qpe_pkg::cmd_t      head_cmd
);
  import qpe_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/qpe_back.sv @@
`default_nettype none
module qpe_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire qpe_pkg::cmd_t head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last
);
  import qpe_pkg::*;

  // Byte slots of one request: soft break, then the part.
  localparam logic [2:0] POS_BRK_EQ = 3'd0;
  localparam logic [2:0] POS_CR     = 3'd1;
  localparam logic [2:0] POS_LF     = 3'd2;
  localparam logic [2:0] POS_PART   = 3'd3;
  localparam logic [2:0] POS_HEX_HI = 3'd4;
  localparam logic [2:0] POS_HEX_LO = 3'd5;

  logic       started;
  logic [2:0] pos;
  logic [2:0] start_pos;
  logic [2:0] cur;
  logic       emit;
  logic       last;
  logic [7:0] byte_sel;

  always_comb begin
    if (head_cmd.kind == KIND_NEWLINE) begin
      start_pos = POS_CR;
    end else if (head_cmd.brk) begin
      start_pos = POS_BRK_EQ;
    end else begin
      start_pos = POS_PART;
    end
    cur  = started ? pos : start_pos;
    emit = head_valid && (!out_valid || out_ready);
    last = ((head_cmd.kind == KIND_NEWLINE) && (cur == POS_LF)) ||
           ((head_cmd.kind == KIND_LITERAL) && (cur == POS_PART)) ||
           ((head_cmd.kind == KIND_ESCAPE)  && (cur == POS_HEX_LO));
    pop  = emit && last;
    case (cur)
      POS_BRK_EQ: byte_sel = CH_EQ;
      POS_CR:     byte_sel = CH_CR;
      POS_LF:     byte_sel = CH_LF;
      POS_PART:   byte_sel = (head_cmd.kind == KIND_LITERAL) ? head_cmd.data : CH_EQ;
      POS_HEX_HI: byte_sel = hex_char(head_cmd.data[7:4]);
      POS_HEX_LO: byte_sel = hex_char(head_cmd.data[3:0]);
      default:    byte_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      pos       <= POS_BRK_EQ;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        started   <= !last;
        pos       <= cur + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= byte_sel;
      out_last <= last;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/qpe_checker.sv @@
`default_nettype none
module qpe_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  // Output stays put while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("qpe: stalled output changed");

  // A CR is never marked last: it is always followed by LF within the same request.
  a_cr_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata == 8'h0D) |-> !m_axis_tlast)
    else $error("qpe: CR marked last");

  // No request ends on '=': escapes end in a hex digit, newlines in LF, literals are never '='.
  a_eq_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata != 8'h3D))
    else $error("qpe: request ended on '='");

  // Nothing comes out in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("qpe: output valid after reset");

  // The queue is empty after reset, so the input side is open.
  a_reset_ready: assert property (@(posedge clk)
    rst |=> s_axis_tready)
    else $error("qpe: input not ready after reset");

endmodule

bind quoted_printable_encoder qpe_checker u_qpe_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
